FILE: rtl/core/sha1c_pkg.sv
package sha1c_pkg;

   // Widths and counts of the SHA-1 block and digest.
   localparam int WordW       = 32;
   localparam int BlockWords  = 16;
   localparam int AddrW       = 4;
   localparam int RoundCount  = 80;
   localparam int RoundW      = 7;
   localparam int DigestWords = 5;
   localparam int IdxW        = 3;
   localparam int CountW      = 64;

   typedef logic [WordW-1:0] word_type;
   typedef logic [DigestWords-1:0][WordW-1:0] chain_type;

   // Initial chaining values; entry 0 is h0.
   localparam chain_type InitChain = {
      32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
   };

   // Round constants, one per group of twenty rounds.
   localparam logic [3:0][WordW-1:0] RoundConst = {
      32'hCA62C1D6, 32'h8F1BBCDC, 32'h6ED9EBA1, 32'h5A827999
   };

   // Round groups.
   localparam logic [1:0] GroupChoose   = 2'd0;
   localparam logic [1:0] GroupParityA  = 2'd1;
   localparam logic [1:0] GroupMajority = 2'd2;
   localparam logic [1:0] GroupParityB  = 2'd3;

   // Padding and block layout.
   localparam logic [7:0]       PadByte       = 8'h80;
   localparam logic [5:0]       LastOffset    = 6'd63;
   localparam logic [AddrW-1:0] LastZeroWord  = 4'd13;
   localparam logic [AddrW-1:0] LenHiWord     = 4'd14;
   localparam logic [AddrW-1:0] LenLoWord     = 4'd15;
   localparam logic [IdxW-1:0]  LastDigestIdx = 3'd4;
   localparam logic [RoundW-1:0] LastRound    = 7'd79;
   localparam logic [RoundW-1:0] FirstExpRound = 7'd16;

   // Commands from the controller to the round engine.
   typedef struct packed {
      logic                 wr_en;
      logic [AddrW-1:0]     wr_addr;
      word_type             wr_data;
      logic                 start;
      logic                 chain_init;
   } load_cmd_type;

   // Status from the round engine.
   typedef struct packed {
      logic busy;
      logic done;
   } round_status_type;

   typedef enum logic [2:0] {
      ROUND_IDLE,
      ROUND_LOAD,
      ROUND_RD_A,
      ROUND_RD_B,
      ROUND_CALC,
      ROUND_SUM
   } round_state_type;

   typedef enum logic [3:0] {
      CTRL_IDLE,
      CTRL_BLOCK,
      CTRL_PAD,
      CTRL_ZERO,
      CTRL_PAD_RUN,
      CTRL_LEN_HI,
      CTRL_LEN_LO,
      CTRL_FINAL,
      CTRL_EMIT
   } ctrl_state_type;

   // Group of a round: twenty rounds each.
   function automatic logic [1:0] round_group(input logic [RoundW-1:0] t);
      logic [1:0] g;
      if (t < 7'd20) begin
         g = GroupChoose;
      end else if (t < 7'd40) begin
         g = GroupParityA;
      end else if (t < 7'd60) begin
         g = GroupMajority;
      end else begin
         g = GroupParityB;
      end
      return g;
   endfunction

   // Boolean function of a round group.
   function automatic word_type round_func(input logic [1:0] g, input word_type b,
                                           input word_type c, input word_type d);
      word_type f;
      case (g)
         GroupChoose:   f = d ^ (b & (c ^ d));
         GroupMajority: f = (b & c) | (d & (b | c));
         default:       f = b ^ c ^ d;
      endcase
      return f;
   endfunction

   // Place a byte into a big-endian word; lower bytes are cleared.
   function automatic word_type insert_byte(input word_type acc, input logic [7:0] v,
                                            input logic [1:0] pos);
      word_type r;
      case (pos)
         2'd0:    r = {v, 24'h000000};
         2'd1:    r = {acc[31:24], v, 16'h0000};
         2'd2:    r = {acc[31:16], v, 8'h00};
         default: r = {acc[31:8], v};
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/core/sha1c_if.sv
// Message byte channel.
interface sha1c_req_if;
   logic       valid;
   logic       ready;
   logic       has_byte;
   logic [7:0] message_byte;
   logic       is_last;

   modport source (output valid, output has_byte, output message_byte, output is_last,
                   input ready);
   modport sink (input valid, input has_byte, input message_byte, input is_last,
                 output ready);
endinterface

// Digest word channel.
interface sha1c_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, output digest_word, output word_index, output last_word,
                   input ready);
   modport sink (input valid, input digest_word, input word_index, input last_word,
                 output ready);
endinterface

FILE: rtl/core/sha1c_rounds.sv
module sha1c_rounds (
   input  logic                       clock,
   input  logic                       reset,
   input  sha1c_pkg::load_cmd_type    load_cmd,
   output sha1c_pkg::round_status_type status,
   output sha1c_pkg::chain_type       chain_words
);
   import sha1c_pkg::*;

   round_state_type     state_ff, state_in;
   logic [RoundW-1:0]   round_ff, round_in;
   word_type            a_ff, b_ff, c_ff, d_ff, e_ff;
   word_type            a_in, b_in, c_in, d_in, e_in;
   word_type            ekf_ff, ekf_in;
   word_type            x_ff, x_in;
   word_type            rd0_ff, rd1_ff;
   chain_type           chain_ff, chain_in;
   logic [AddrW-1:0]    addr0, addr1, mem_addr;
   logic                sched_we, mem_we;
   word_type            w_val, mem_data, temp;
   logic [1:0]          group;
   logic                expand;

   // Message schedule memory, one write and two registered reads per cycle.
   word_type sched_mem [BlockWords];

   assign expand = (round_ff >= FirstExpRound);
   assign group  = round_group(round_ff);

   // Schedule word of the current round.
   always_comb begin
      word_type x;
      x = x_ff ^ rd0_ff ^ rd1_ff;
      w_val = expand ? {x[30:0], x[31]} : rd0_ff;
   end

   assign temp = {a_ff[26:0], a_ff[31:27]} + ekf_ff + w_val;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ROUND_IDLE: if (load_cmd.start) state_in = ROUND_LOAD;
         ROUND_LOAD: state_in = ROUND_RD_A;
         ROUND_RD_A: state_in = expand ? ROUND_RD_B : ROUND_CALC;
         ROUND_RD_B: state_in = ROUND_CALC;
         ROUND_CALC: state_in = (round_ff == LastRound) ? ROUND_SUM : ROUND_RD_A;
         ROUND_SUM:  state_in = ROUND_IDLE;
         default:    state_in = ROUND_IDLE;
      endcase
   end

   // Datapath control and next values.
   always_comb begin
      round_in = round_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      d_in     = d_ff;
      e_in     = e_ff;
      ekf_in   = ekf_ff;
      x_in     = x_ff;
      chain_in = chain_ff;
      addr0    = round_ff[AddrW-1:0];
      addr1    = round_ff[AddrW-1:0];
      sched_we = 1'b0;
      case (state_ff)
         ROUND_IDLE: begin
            if (load_cmd.chain_init) chain_in = InitChain;
         end
         ROUND_LOAD: begin
            a_in = chain_ff[0];
            b_in = chain_ff[1];
            c_in = chain_ff[2];
            d_in = chain_ff[3];
            e_in = chain_ff[4];
         end
         ROUND_RD_A: begin
            // Fetch w[t] or the first two taps; fold e, K and f meanwhile.
            addr0  = expand ? round_ff[AddrW-1:0] - 4'd3 : round_ff[AddrW-1:0];
            addr1  = round_ff[AddrW-1:0] - 4'd8;
            ekf_in = e_ff + RoundConst[group] + round_func(group, b_ff, c_ff, d_ff);
         end
         ROUND_RD_B: begin
            x_in  = rd0_ff ^ rd1_ff;
            addr0 = round_ff[AddrW-1:0] - 4'd14;
            addr1 = round_ff[AddrW-1:0];
         end
         ROUND_CALC: begin
            sched_we = expand;
            a_in     = temp;
            b_in     = a_ff;
            c_in     = {b_ff[1:0], b_ff[31:2]};
            d_in     = c_ff;
            e_in     = d_ff;
            round_in = (round_ff == LastRound) ? '0 : round_ff + RoundW'(1);
         end
         ROUND_SUM: begin
            chain_in[0] = chain_ff[0] + a_ff;
            chain_in[1] = chain_ff[1] + b_ff;
            chain_in[2] = chain_ff[2] + c_ff;
            chain_in[3] = chain_ff[3] + d_ff;
            chain_in[4] = chain_ff[4] + e_ff;
         end
         default: begin
            round_in = '0;
         end
      endcase
   end

   // Memory write port is shared by block loads and schedule expansion.
   assign mem_we   = sched_we | load_cmd.wr_en;
   assign mem_addr = sched_we ? round_ff[AddrW-1:0] : load_cmd.wr_addr;
   assign mem_data = sched_we ? w_val : load_cmd.wr_data;

   always_ff @(posedge clock) begin
      if (mem_we) sched_mem[mem_addr] <= mem_data;
      rd0_ff <= sched_mem[addr0];
      rd1_ff <= sched_mem[addr1];
   end

   // Control and chaining state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ROUND_IDLE;
         round_ff <= '0;
         chain_ff <= InitChain;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         chain_ff <= chain_in;
      end
   end

   // Working variables.
   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
      e_ff   <= e_in;
      ekf_ff <= ekf_in;
      x_ff   <= x_in;
   end

   assign status.busy = (state_ff != ROUND_IDLE);
   assign status.done = (state_ff == ROUND_SUM);
   assign chain_words = chain_ff;

   // A block is started only when the engine is free.
   assert property (@(posedge clock) disable iff (reset)
      load_cmd.start |-> (state_ff == ROUND_IDLE))
      else $error("block start while round engine busy");

   // The engine returns to idle right after the chaining sum.
   assert property (@(posedge clock) disable iff (reset)
      status.done |=> (state_ff == ROUND_IDLE))
      else $error("round engine did not return to idle");

   // Round counter stays within the eighty rounds.
   assert property (@(posedge clock) disable iff (reset)
      1'b1 |-> (round_ff <= LastRound))
      else $error("round counter out of range");

endmodule

FILE: rtl/core/sha1c_ctrl.sv
module sha1c_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   sha1c_req_if.sink                   req_port,
   sha1c_rsp_if.source                 rsp_port,
   output sha1c_pkg::load_cmd_type     load_cmd,
   input  sha1c_pkg::round_status_type status,
   input  sha1c_pkg::chain_type        chain_words
);
   import sha1c_pkg::*;

   ctrl_state_type      state_ff, state_in;
   logic [CountW-1:0]   count_ff, count_in;
   word_type            acc_ff, acc_in;
   logic [AddrW-1:0]    fill_ff, fill_in;
   logic                tail_ff, tail_in;
   logic                pend_ff, pend_in;
   logic [IdxW-1:0]     idx_ff, idx_in;
   logic [5:0]          off;
   logic [AddrW-1:0]    wi;
   logic [CountW-1:0]   bit_len;
   logic                req_beat, rsp_beat;

   assign off      = count_ff[5:0];
   assign wi       = off[5:2];
   assign bit_len  = {count_ff[CountW-4:0], 3'b000};
   assign req_beat = req_port.valid & req_port.ready;
   assign rsp_beat = rsp_port.valid & rsp_port.ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CTRL_IDLE: begin
            if (req_beat) begin
               if (req_port.has_byte && off == LastOffset) begin
                  state_in = CTRL_BLOCK;
               end else if (req_port.is_last) begin
                  state_in = CTRL_PAD;
               end
            end
         end
         CTRL_BLOCK: begin
            if (status.done) state_in = pend_ff ? CTRL_PAD : CTRL_IDLE;
         end
         CTRL_PAD: begin
            if (wi == LenLoWord) begin
               state_in = CTRL_PAD_RUN;
            end else if (wi == LastZeroWord) begin
               state_in = CTRL_LEN_HI;
            end else begin
               state_in = CTRL_ZERO;
            end
         end
         CTRL_ZERO: begin
            if (tail_ff && fill_ff == LenLoWord) begin
               state_in = CTRL_PAD_RUN;
            end else if (!tail_ff && fill_ff == LastZeroWord) begin
               state_in = CTRL_LEN_HI;
            end
         end
         CTRL_PAD_RUN: if (status.done) state_in = CTRL_ZERO;
         CTRL_LEN_HI:  state_in = CTRL_LEN_LO;
         CTRL_LEN_LO:  state_in = CTRL_FINAL;
         CTRL_FINAL:   if (status.done) state_in = CTRL_EMIT;
         CTRL_EMIT:    if (rsp_beat && idx_ff == LastDigestIdx) state_in = CTRL_IDLE;
         default:      state_in = CTRL_IDLE;
      endcase
   end

   // Outputs and datapath next values.
   always_comb begin
      count_in       = count_ff;
      acc_in         = acc_ff;
      fill_in        = fill_ff;
      tail_in        = tail_ff;
      pend_in        = pend_ff;
      idx_in         = idx_ff;
      load_cmd       = '0;
      req_port.ready = 1'b0;
      rsp_port.valid = 1'b0;
      case (state_ff)
         CTRL_IDLE: begin
            // Store each byte by rewriting its whole word.
            req_port.ready = 1'b1;
            if (req_beat && req_port.has_byte) begin
               acc_in           = insert_byte(acc_ff, req_port.message_byte, off[1:0]);
               load_cmd.wr_en   = 1'b1;
               load_cmd.wr_addr = wi;
               load_cmd.wr_data = acc_in;
               count_in         = count_ff + CountW'(1);
               load_cmd.start   = (off == LastOffset);
               pend_in          = req_port.is_last;
            end
         end
         CTRL_PAD: begin
            // Word that holds the pad byte.
            load_cmd.wr_en   = 1'b1;
            load_cmd.wr_addr = wi;
            load_cmd.wr_data = insert_byte(acc_ff, PadByte, off[1:0]);
            load_cmd.start   = (wi == LenLoWord);
            fill_in          = wi + AddrW'(1);
            tail_in          = (wi >= LenHiWord);
         end
         CTRL_ZERO: begin
            load_cmd.wr_en   = 1'b1;
            load_cmd.wr_addr = fill_ff;
            load_cmd.wr_data = '0;
            load_cmd.start   = tail_ff && (fill_ff == LenLoWord);
            fill_in          = fill_ff + AddrW'(1);
         end
         CTRL_PAD_RUN: begin
            fill_in = '0;
            tail_in = 1'b0;
         end
         CTRL_LEN_HI: begin
            load_cmd.wr_en   = 1'b1;
            load_cmd.wr_addr = LenHiWord;
            load_cmd.wr_data = bit_len[63:32];
         end
         CTRL_LEN_LO: begin
            load_cmd.wr_en   = 1'b1;
            load_cmd.wr_addr = LenLoWord;
            load_cmd.wr_data = bit_len[31:0];
            load_cmd.start   = 1'b1;
         end
         CTRL_EMIT: begin
            // Send h0..h4, then start a new message.
            rsp_port.valid = 1'b1;
            if (rsp_beat) begin
               if (idx_ff == LastDigestIdx) begin
                  idx_in              = '0;
                  count_in            = '0;
                  load_cmd.chain_init = 1'b1;
               end else begin
                  idx_in = idx_ff + IdxW'(1);
               end
            end
         end
         default: begin
            pend_in = pend_ff;
         end
      endcase
   end

   assign rsp_port.digest_word = chain_words[idx_ff];
   assign rsp_port.word_index  = idx_ff;
   assign rsp_port.last_word   = (idx_ff == LastDigestIdx);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTRL_IDLE;
         count_ff <= '0;
         idx_ff   <= '0;
         pend_ff  <= 1'b0;
         tail_ff  <= 1'b0;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         pend_ff  <= pend_in;
         tail_ff  <= tail_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // Block memory is loaded only while the round engine is idle.
   assert property (@(posedge clock) disable iff (reset)
      load_cmd.wr_en |-> !status.busy)
      else $error("block write during rounds");

   // New bytes are taken only while no block is in flight.
   assert property (@(posedge clock) disable iff (reset)
      req_port.ready |-> !status.busy)
      else $error("byte accepted while rounds run");

   // After the final digest beat the message state starts over.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_beat && rsp_port.last_word) |=> (count_ff == '0 && state_ff == CTRL_IDLE))
      else $error("message state not cleared after digest");

endmodule

FILE: rtl/core/sha1_hash_engine_core.sv
// Byte beats that do not complete a block are taken back to back.
// Completing a 64-byte block holds further beats while the rounds run: a load, 16 rounds
// of read and calculate, 64 with an extra read through the two read ports of the schedule
// memory, then the chaining sum. Last beat: up to 18 padding word writes, one or two blocks,
// then 5 digest beats, one per cycle when the receiver is ready.
// Synchronous reset restores the initial chaining values and clears the byte count.
module sha1_hash_engine_core (
   input  logic         clock,
   input  logic         reset,
   sha1c_req_if.sink    req_port,
   sha1c_rsp_if.source  rsp_port
);
   import sha1c_pkg::*;

   load_cmd_type     load_cmd;
   round_status_type status;
   chain_type        chain_words;

   // Message intake, padding and digest output.
   sha1c_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_port    (req_port),
      .rsp_port    (rsp_port),
      .load_cmd    (load_cmd),
      .status      (status),
      .chain_words (chain_words)
   );

   // Schedule memory and compression rounds.
   sha1c_rounds u_rounds (
      .clock       (clock),
      .reset       (reset),
      .load_cmd    (load_cmd),
      .status      (status),
      .chain_words (chain_words)
   );

endmodule

FILE: tb/sv/tb.sv
module tb;

   // Beat on the message side and beat on the digest side.
   typedef struct packed {
      logic       has_byte;
      logic [7:0] message_byte;
      logic       is_last;
   } msg_beat_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } digest_beat_type;

   // Stages of the run; each sets how much the two sides idle.
   typedef enum int {
      PH_DIRECTED,
      PH_PRESSURE,
      PH_SEND_IDLE,
      PH_RECV_STALL,
      PH_BOTH_IDLE
   } phase_type;

   localparam logic [4:0][31:0] ChainInit = {
      32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
   };
   localparam logic [3:0][31:0] StageConst = {
      32'hCA62C1D6, 32'h8F1BBCDC, 32'h6ED9EBA1, 32'h5A827999
   };
   localparam logic [7:0] PadMark      = 8'h80;
   localparam int         LenOffset    = 56;
   localparam int         BlockBytes   = 64;
   localparam int         LastIdx      = 4;
   localparam int         HoldCycles   = 600;
   localparam int         SettleCycles = 300;
   localparam int         CycleLimit   = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sha1c_req_if req_bus ();
   sha1c_rsp_if rsp_bus ();

   sha1_hash_engine_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   msg_beat_type    beat_q [$];
   digest_beat_type digest_q [$];
   msg_beat_type    offered_beat;
   phase_type       phase = PH_DIRECTED;
   int              send_idle_pct = 0;
   int              recv_stall_pct = 0;
   int              fail_count = 0;
   int              cycle_count = 0;
   int              hold_left = 0;
   logic            hold_armed = 1'b0;

   // Hash state of the expected behavior.
   logic [31:0] chain_h [5];
   logic [31:0] sched_w [16];
   logic [63:0] byte_total;

   function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned n);
      return (x << n) | (x >> (32 - n));
   endfunction

   // Eighty rounds over the current block, folded into the chaining words.
   task automatic compress_block();
      logic [31:0] a, b, c, d, e, f, k, w, tmp;
      int t;
      a = chain_h[0];
      b = chain_h[1];
      c = chain_h[2];
      d = chain_h[3];
      e = chain_h[4];
      for (t = 0; t < 80; t++) begin
         if (t < 16) begin
            w = sched_w[t];
         end else begin
            w = rotl32(sched_w[(t - 3) & 15] ^ sched_w[(t - 8) & 15] ^
                       sched_w[(t - 14) & 15] ^ sched_w[t & 15], 1);
            sched_w[t & 15] = w;
         end
         if (t < 20) begin
            f = d ^ (b & (c ^ d));
         end else if (t >= 40 && t < 60) begin
            f = (b & c) | (d & (b | c));
         end else begin
            f = b ^ c ^ d;
         end
         k = StageConst[t / 20];
         tmp = rotl32(a, 5) + f + e + k + w;
         e = d;
         d = c;
         c = rotl32(b, 30);
         b = a;
         a = tmp;
      end
      chain_h[0] += a;
      chain_h[1] += b;
      chain_h[2] += c;
      chain_h[3] += d;
      chain_h[4] += e;
   endtask

   // Bytes land big-endian; the first byte of a word clears the rest of it.
   task automatic place_byte(input int unsigned off, input logic [7:0] v);
      int unsigned wi;
      int unsigned sh;
      wi = off >> 2;
      sh = (3 - (off & 3)) * 8;
      if ((off & 3) == 0) begin
         sched_w[wi] = {v, 24'h000000};
      end else begin
         sched_w[wi][sh +: 8] = v;
      end
   endtask

   task automatic restart_hash();
      int k;
      for (k = 0; k < 5; k++) begin
         chain_h[k] = ChainInit[k];
      end
      byte_total = '0;
   endtask

   // Works out the digest beats that one accepted message beat causes.
   task automatic predict_digest(input msg_beat_type beat);
      int unsigned     off;
      logic [63:0]     bits;
      digest_beat_type dw;
      int              k;
      if (beat.has_byte) begin
         off = byte_total[5:0];
         place_byte(off, beat.message_byte);
         byte_total++;
         if (off == BlockBytes - 1) begin
            compress_block();
         end
      end
      if (beat.is_last) begin
         bits = byte_total << 3;
         off = byte_total[5:0];
         place_byte(off, PadMark);
         off++;
         // No room left for the length: close this block and open another.
         if (off > LenOffset) begin
            while (off < BlockBytes) begin
               place_byte(off, 8'h00);
               off++;
            end
            compress_block();
            off = 0;
         end
         while (off < LenOffset) begin
            place_byte(off, 8'h00);
            off++;
         end
         sched_w[14] = bits[63:32];
         sched_w[15] = bits[31:0];
         compress_block();
         for (k = 0; k < 5; k++) begin
            dw.digest_word = chain_h[k];
            dw.word_index  = k[2:0];
            dw.last_word   = (k == LastIdx);
            digest_q.push_back(dw);
         end
         restart_hash();
      end
   endtask

   function automatic void push_beat(input logic has, input logic [7:0] v, input logic last);
      msg_beat_type b;
      b.has_byte     = has;
      b.message_byte = v;
      b.is_last      = last;
      beat_q.push_back(b);
   endfunction

   // Queues one message of len bytes with random content and some idle noise beats.
   // Returns the number of beats queued.
   function automatic int push_message(input int len);
      int i;
      int body;
      int n;
      logic byte_on_last;
      byte_on_last = (len > 0) && ($urandom_range(1) == 1);
      body = byte_on_last ? len - 1 : len;
      n = 0;
      for (i = 0; i < body; i++) begin
         if ($urandom_range(7) == 0) begin
            push_beat(1'b0, 8'($urandom), 1'b0);
            n++;
         end
         push_beat(1'b1, 8'($urandom), 1'b0);
         n++;
      end
      push_beat(byte_on_last, 8'($urandom), 1'b1);
      return n + 1;
   endfunction

   // Mostly short messages; some sit on the padding and block boundaries.
   function automatic int pick_length();
      int len;
      case ($urandom_range(3))
         0: begin
            case ($urandom_range(7))
               0: len = 51;
               1: len = 52;
               2: len = 55;
               3: len = 56;
               4: len = 57;
               5: len = 63;
               6: len = 64;
               default: len = 65;
            endcase
         end
         default: len = $urandom_range(0, 12);
      endcase
      return len;
   endfunction

   // Message driver: offers queued beats, idling at the phase's rate.
   always @(posedge clock) begin
      msg_beat_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_digest(offered_beat);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (beat_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = beat_q.pop_front();
               offered_beat = nxt;
               req_bus.valid        <= 1'b1;
               req_bus.has_byte     <= nxt.has_byte;
               req_bus.message_byte <= nxt.message_byte;
               req_bus.is_last      <= nxt.is_last;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Digest monitor: checks each accepted beat against the oldest expectation.
   always @(posedge clock) begin
      digest_beat_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (digest_q.size() == 0) begin
               $error("digest beat with nothing expected: word %h index %0d",
                      rsp_bus.digest_word, rsp_bus.word_index);
               fail_count++;
            end else begin
               want = digest_q.pop_front();
               if (rsp_bus.digest_word !== want.digest_word) begin
                  $error("digest_word: expected %h, actual %h",
                         want.digest_word, rsp_bus.digest_word);
                  fail_count++;
               end
               if (rsp_bus.word_index !== want.word_index) begin
                  $error("word_index: expected %0d, actual %0d",
                         want.word_index, rsp_bus.word_index);
                  fail_count++;
               end
               if (rsp_bus.last_word !== want.last_word) begin
                  $error("last_word: expected %0d, actual %0d",
                         want.last_word, rsp_bus.last_word);
                  fail_count++;
               end
            end
         end
         if (hold_left != 0) begin
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // One long receiver hold-off at the start of the pressure phase.
   always @(posedge clock) begin
      if (reset) begin
         hold_left  <= 0;
         hold_armed <= 1'b0;
      end else if (phase == PH_PRESSURE && !hold_armed) begin
         hold_left  <= HoldCycles;
         hold_armed <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("FAIL");
         $finish;
      end
   end

   // Sender pause: wait until every queued beat went out and every digest came back.
   task automatic drain_all();
      while (beat_q.size() != 0 || digest_q.size() != 0 || req_bus.valid) begin
         @(negedge clock);
      end
      repeat (20) @(negedge clock);
   endtask

   initial begin
      int n_items;
      int p;
      req_bus.valid        = 1'b0;
      req_bus.has_byte     = 1'b0;
      req_bus.message_byte = 8'h00;
      req_bus.is_last      = 1'b0;
      rsp_bus.ready        = 1'b0;
      restart_hash();
      for (p = 0; p < 16; p++) begin
         sched_w[p] = '0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed beats: idle noise, empty message, a short text, byte extremes,
      // an empty last beat after data, and back-to-back messages.
      push_beat(1'b0, 8'hFF, 1'b0);
      push_beat(1'b0, 8'h00, 1'b1);
      push_beat(1'b1, 8'h61, 1'b0);
      push_beat(1'b1, 8'h62, 1'b0);
      push_beat(1'b1, 8'h63, 1'b1);
      push_beat(1'b0, 8'hA5, 1'b0);
      push_beat(1'b1, 8'h00, 1'b1);
      push_beat(1'b1, 8'hFF, 1'b0);
      push_beat(1'b0, 8'h5A, 1'b1);
      push_beat(1'b1, 8'hFF, 1'b1);
      push_beat(1'b0, 8'hFF, 1'b1);
      drain_all();

      // Random messages, one phase per idling pattern.
      for (p = PH_PRESSURE; p <= PH_BOTH_IDLE; p++) begin
         phase = phase_type'(p);
         case (phase)
            PH_SEND_IDLE: begin
               send_idle_pct  = 70;
               recv_stall_pct = 0;
            end
            PH_RECV_STALL: begin
               send_idle_pct  = 0;
               recv_stall_pct = 70;
            end
            PH_BOTH_IDLE: begin
               send_idle_pct  = 20;
               recv_stall_pct = 20;
            end
            default: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
         endcase
         n_items = 0;
         // A short first message under the hold-off backs the block up quickly.
         if (phase == PH_PRESSURE) begin
            n_items += push_message($urandom_range(1, 8));
         end
         while (n_items < 15) begin
            n_items += push_message(pick_length());
         end
         drain_all();
      end

      repeat (SettleCycles) @(negedge clock);
      if (fail_count == 0 && digest_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/sha1c_pkg.sv
rtl/core/sha1c_if.sv
rtl/core/sha1c_rounds.sv
rtl/core/sha1c_ctrl.sv
rtl/core/sha1_hash_engine_core.sv
tb/sv/tb.sv
